>>> rtl/gtb_pkg.sv
// Shared constants, request type and font table for the glyph text blitter.
package gtb_pkg;

  localparam int PAGE_SIZE   = 64;
  localparam int MAX_TEXT    = 255;
  localparam int CELLS       = PAGE_SIZE * PAGE_SIZE;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int POS_W       = 13;
  localparam int GLYPH_ROWS  = 5;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_PITCH = 6;

  localparam logic signed [POS_W-1:0] PAGE_S  = POS_W'(PAGE_SIZE);
  localparam logic signed [POS_W-1:0] HALF_S  = POS_W'(PAGE_SIZE / 2);
  localparam logic signed [POS_W-1:0] PITCH_S = POS_W'(GLYPH_PITCH);
  localparam logic signed [POS_W-1:0] HPITCH_S = POS_W'(GLYPH_PITCH / 2);

  localparam logic [7:0] CELL_BLANK = 8'd46;
  localparam logic [7:0] CELL_SPACE = 8'd32;
  localparam logic [7:0] CELL_INK   = 8'd42;
  localparam logic [7:0] CHAR_A     = 8'd65;
  localparam logic [7:0] CHAR_Z     = 8'd90;

  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ALIGN_LEFT   = 2'd0;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd1;
  localparam logic [1:0] ALIGN_CENTRE = 2'd2;

  typedef enum logic [1:0] {
    K_CELL,
    K_GLYPH,
    K_READ,
    K_CLEAR
  } gtb_kind_t;

  // One classified request on its way to the back end
  typedef struct packed {
    gtb_kind_t                kind;
    logic [5:0]               row;
    logic signed [POS_W-1:0]  col;
    logic [7:0]               data;
    logic                     in_page;
  } gtb_req_t;

  // Glyph rows top to bottom, bit 4 of each row is the leftmost column
  localparam logic [24:0] FONT_ROM [26] = '{
    {5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11}, {5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E},
    {5'h0F, 5'h11, 5'h10, 5'h10, 5'h0F}, {5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E},
    {5'h1F, 5'h10, 5'h1C, 5'h10, 5'h1F}, {5'h1F, 5'h10, 5'h1C, 5'h10, 5'h10},
    {5'h0F, 5'h10, 5'h13, 5'h11, 5'h0E}, {5'h11, 5'h11, 5'h1F, 5'h11, 5'h11},
    {5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F}, {5'h07, 5'h02, 5'h02, 5'h12, 5'h0C},
    {5'h11, 5'h12, 5'h1C, 5'h12, 5'h11}, {5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
    {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11}, {5'h11, 5'h19, 5'h15, 5'h13, 5'h11},
    {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E}, {5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10},
    {5'h0E, 5'h11, 5'h11, 5'h13, 5'h0F}, {5'h1E, 5'h11, 5'h1E, 5'h12, 5'h11},
    {5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E}, {5'h1F, 5'h15, 5'h04, 5'h04, 5'h0E},
    {5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, {5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04},
    {5'h11, 5'h11, 5'h15, 5'h1B, 5'h11}, {5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11},
    {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04}, {5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F}
  };

  function automatic logic font_bit(input logic [4:0] idx, input logic [2:0] i,
                                    input logic [2:0] j);
    logic [24:0] g;
    logic [4:0]  k;
    g = (idx < 5'd26) ? FONT_ROM[idx] : '0;
    k = 5'(24 - GLYPH_COLS * int'(i) - int'(j));
    return g[k];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [6:0] r,
                                                  input logic [6:0] c);
    logic [13:0] a;
    a = {7'b0, r} * 14'(PAGE_SIZE) + {7'b0, c};
    return a[ADDR_W-1:0];
  endfunction

endpackage

>>> rtl/glyph_text_blitter.sv
// Top level of the glyph text blitter: front end, request queue and back end.
//
//   channel  ports                                   handshake
//   in       in_command .. in_char_code              start high, busy low
//   out      out_cell_value                          out_strobe, one cycle
//
// A single-cell draw is one back-end write; a large glyph is swept by the one
// page memory write port over 5x5 pixels. An accepted read passes the queue
// slot, then the read data register, before its result shows. A clear sweeps
// the memory one cell a cycle over all PAGE_SIZE*PAGE_SIZE (4096) cells. After
// reset the same pass runs with busy high. busy also rises while the
// two-entry request queue is full; results are never held back.
module glyph_text_blitter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_command,
  input  logic [1:0] in_align,
  input  logic       in_large_font,
  input  logic [5:0] in_row,
  input  logic [5:0] in_column,
  input  logic [7:0] in_text_length,
  input  logic [7:0] in_char_position,
  input  logic [7:0] in_char_code,
  output logic       out_strobe,
  output logic [7:0] out_cell_value
);
  import gtb_pkg::*;

  logic     push;
  gtb_req_t push_req;
  logic     pop;
  gtb_req_t pop_req;
  logic     q_full;
  logic     q_empty;
  logic     init_busy;

  assign busy = q_full || init_busy;

  gtb_front u_front (
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_align         (in_align),
    .in_large_font    (in_large_font),
    .in_row           (in_row),
    .in_column        (in_column),
    .in_text_length   (in_text_length),
    .in_char_position (in_char_position),
    .in_char_code     (in_char_code),
    .push             (push),
    .push_req         (push_req)
  );

  gtb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .pop_req  (pop_req),
    .full     (q_full),
    .empty    (q_empty)
  );

  gtb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_req          (pop_req),
    .pop            (pop),
    .init_busy      (init_busy),
    .out_strobe     (out_strobe),
    .out_cell_value (out_cell_value)
  );

endmodule

>>> rtl/gtb_front.sv
// Front end: takes a request, works out placement and clipping, and queues it.
module gtb_front (
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_command,
  input  logic [1:0]        in_align,
  input  logic              in_large_font,
  input  logic [5:0]        in_row,
  input  logic [5:0]        in_column,
  input  logic [7:0]        in_text_length,
  input  logic [7:0]        in_char_position,
  input  logic [7:0]        in_char_code,
  output logic              push,
  output gtb_pkg::gtb_req_t push_req
);
  import gtb_pkg::*;

  logic [7:0]              len;
  logic signed [POS_W-1:0] len_s;
  logic signed [POS_W-1:0] pos_s;
  logic signed [POS_W-1:0] col_s;
  logic signed [POS_W-1:0] x_small;
  logic signed [POS_W-1:0] x_large;
  logic                    skip;
  logic                    row_in;
  logic                    x_in;
  logic                    letter;

  assign len   = (in_text_length > 8'(MAX_TEXT)) ? 8'(MAX_TEXT) : in_text_length;
  assign len_s = $signed({5'b0, len});
  assign pos_s = $signed({5'b0, in_char_position});
  assign col_s = $signed({7'b0, in_column});

  assign skip   = (in_char_code == CELL_SPACE) || (in_char_position >= len) ||
                  (in_align > ALIGN_CENTRE);
  assign row_in = {1'b0, in_row} < 7'(PAGE_SIZE);
  assign x_in   = !x_small[POS_W-1] && (x_small < PAGE_S);
  assign letter = (in_char_code >= CHAR_A) && (in_char_code <= CHAR_Z);

  always_comb begin
    case (in_align)
      ALIGN_LEFT: begin
        x_small = col_s + pos_s;
        x_large = col_s + PITCH_S * pos_s;
      end
      ALIGN_RIGHT: begin
        x_small = PAGE_S - len_s + pos_s;
        x_large = PAGE_S - PITCH_S * (len_s - pos_s);
      end
      ALIGN_CENTRE: begin
        x_small = HALF_S - (len_s >>> 1) + pos_s;
        x_large = HALF_S - HPITCH_S * len_s + PITCH_S * pos_s;
      end
      default: begin
        x_small = '0;
        x_large = '0;
      end
    endcase
  end

  always_comb begin
    logic go;
    go               = 1'b0;
    push_req.kind    = K_CELL;
    push_req.row     = in_row;
    push_req.col     = col_s;
    push_req.data    = in_char_code;
    push_req.in_page = 1'b0;
    case (in_command)
      CMD_DRAW: begin
        if (!skip && !in_large_font) begin
          go           = row_in && x_in;
          push_req.col = x_small;
        end else if (!skip && letter) begin
          go            = 1'b1;
          push_req.kind = K_GLYPH;
          push_req.col  = x_large;
          push_req.data = in_char_code - CHAR_A;
        end
      end
      CMD_READ: begin
        go               = 1'b1;
        push_req.kind    = K_READ;
        push_req.in_page = row_in && ({1'b0, in_column} < 7'(PAGE_SIZE));
      end
      CMD_CLEAR: begin
        go            = 1'b1;
        push_req.kind = K_CLEAR;
      end
      default: go = 1'b0;
    endcase
    push = start && !busy && go;
  end

endmodule

>>> rtl/gtb_queue.sv
// Two-entry request queue between the front and back ends.
module gtb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gtb_pkg::gtb_req_t push_req,
  input  logic              pop,
  output gtb_pkg::gtb_req_t pop_req,
  output logic              full,
  output logic              empty
);
  import gtb_pkg::*;

  gtb_req_t   slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign pop_req = slot_r[rd_ptr_r];
  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_req;
  end

endmodule

>>> rtl/gtb_back.sv
// Back end: page memory, glyph sweep, clearing pass and cell reads.
module gtb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  gtb_pkg::gtb_req_t q_req,
  output logic              pop,
  output logic              init_busy,
  output logic              out_strobe,
  output logic [7:0]        out_cell_value
);
  import gtb_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GLYPH
  } state_t;

  logic [7:0] mem [CELLS];

  state_t                  state_r, state_nxt;
  logic [ADDR_W-1:0]       clr_addr_r, clr_addr_nxt;
  logic                    init_r, init_nxt;
  logic [5:0]              g_row_r, g_row_nxt;
  logic signed [POS_W-1:0] g_x0_r, g_x0_nxt;
  logic [4:0]              g_letter_r, g_letter_nxt;
  logic [2:0]              g_i_r, g_i_nxt;
  logic [2:0]              g_j_r, g_j_nxt;
  logic                    rd_valid_r, rd_valid_nxt;
  logic                    rd_inside_r, rd_inside_nxt;
  logic [7:0]              rd_data_r;

  logic [6:0]              g_row;
  logic signed [POS_W-1:0] g_col;
  logic                    g_hit;
  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  logic [7:0]              wdata;
  logic                    rd_en;
  logic [ADDR_W-1:0]       q_addr;

  assign pop            = (state_r == ST_IDLE) && !q_empty;
  assign init_busy      = init_r;
  assign out_strobe     = rd_valid_r;
  assign out_cell_value = rd_inside_r ? rd_data_r : 8'd0;

  assign q_addr = cell_addr({1'b0, q_req.row}, q_req.col[6:0]);
  assign g_row  = {1'b0, g_row_r} + {4'b0, g_i_r};
  assign g_col  = g_x0_r + $signed({{(POS_W-3){1'b0}}, g_j_r});
  assign g_hit  = font_bit(g_letter_r, g_i_r, g_j_r) && (g_row < 7'(PAGE_SIZE)) &&
                  !g_col[POS_W-1] && (g_col < PAGE_S);
  assign rd_en  = pop && (q_req.kind == K_READ);

  always_comb begin
    we    = 1'b0;
    waddr = q_addr;
    wdata = q_req.data;
    case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr_r;
        wdata = CELL_BLANK;
      end
      ST_GLYPH: begin
        we    = g_hit;
        waddr = cell_addr(g_row, g_col[6:0]);
        wdata = CELL_INK;
      end
      ST_IDLE: we = pop && (q_req.kind == K_CELL);
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    init_nxt      = init_r;
    g_row_nxt     = g_row_r;
    g_x0_nxt      = g_x0_r;
    g_letter_nxt  = g_letter_r;
    g_i_nxt       = g_i_r;
    g_j_nxt       = g_j_r;
    rd_valid_nxt  = rd_en;
    rd_inside_nxt = rd_en ? q_req.in_page : rd_inside_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
          init_nxt  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (pop && q_req.kind == K_GLYPH) begin
          state_nxt    = ST_GLYPH;
          g_row_nxt    = q_req.row;
          g_x0_nxt     = q_req.col;
          g_letter_nxt = q_req.data[4:0];
          g_i_nxt      = 3'd0;
          g_j_nxt      = 3'd0;
        end else if (pop && q_req.kind == K_CLEAR) begin
          state_nxt    = ST_CLEAR;
          clr_addr_nxt = '0;
        end
      end
      ST_GLYPH: begin
        // advance across the row, then down; the pitch column is never written
        if (g_j_r == 3'(GLYPH_COLS - 1)) begin
          g_j_nxt = 3'd0;
          g_i_nxt = g_i_r + 3'd1;
          if (g_i_r == 3'(GLYPH_ROWS - 1)) state_nxt = ST_IDLE;
        end else begin
          g_j_nxt = g_j_r + 3'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      init_r      <= 1'b1;
      rd_valid_r  <= 1'b0;
      rd_inside_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      init_r      <= init_nxt;
      rd_valid_r  <= rd_valid_nxt;
      rd_inside_r <= rd_inside_nxt;
    end
    g_row_r    <= g_row_nxt;
    g_x0_r     <= g_x0_nxt;
    g_letter_r <= g_letter_nxt;
    g_i_r      <= g_i_nxt;
    g_j_r      <= g_j_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[q_addr];
  end

endmodule

>>> dv/glyph_text_blitter_test.sv
// Self-checking testbench for the glyph text blitter: page mirror, request driver, read checker.
`timescale 1ns / 100ps

module glyph_text_blitter_test;
  import gtb_pkg::*;

  localparam logic [1:0] CMD_NONE   = 2'd3;
  localparam logic [1:0] ALIGN_NONE = 2'd3;
  localparam int TIMEOUT_CYCLES = 20_000_000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int PHASE_REQUESTS = 350;

  // Mirror of the character page; holds the cell values that reads must return
  class page_mirror;
    bit [7:0]  cells [CELLS];
    bit [24:0] glyphs [26];
    bit [7:0]  pending_reads [$];
    int        errors;

    function new();
      glyphs = '{
        {5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11}, {5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E},
        {5'h0F, 5'h11, 5'h10, 5'h10, 5'h0F}, {5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E},
        {5'h1F, 5'h10, 5'h1C, 5'h10, 5'h1F}, {5'h1F, 5'h10, 5'h1C, 5'h10, 5'h10},
        {5'h0F, 5'h10, 5'h13, 5'h11, 5'h0E}, {5'h11, 5'h11, 5'h1F, 5'h11, 5'h11},
        {5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F}, {5'h07, 5'h02, 5'h02, 5'h12, 5'h0C},
        {5'h11, 5'h12, 5'h1C, 5'h12, 5'h11}, {5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
        {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11}, {5'h11, 5'h19, 5'h15, 5'h13, 5'h11},
        {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E}, {5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10},
        {5'h0E, 5'h11, 5'h11, 5'h13, 5'h0F}, {5'h1E, 5'h11, 5'h1E, 5'h12, 5'h11},
        {5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E}, {5'h1F, 5'h15, 5'h04, 5'h04, 5'h0E},
        {5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, {5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04},
        {5'h11, 5'h11, 5'h15, 5'h1B, 5'h11}, {5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11},
        {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04}, {5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F}
      };
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (cells[k]) cells[k] = CELL_BLANK;
    endfunction

    // Drop anything that falls off the page
    function void put(int r, int c, bit [7:0] v);
      if (r >= 0 && r < PAGE_SIZE && c >= 0 && c < PAGE_SIZE)
        cells[r * PAGE_SIZE + c] = v;
    endfunction

    function void plot(bit [1:0] align, bit big_font, int row, int col, int len, int pos,
                       bit [7:0] code);
      int x;
      bit [24:0] g;
      if (code == CELL_SPACE || pos >= len || align == ALIGN_NONE)
        return;
      if (!big_font) begin
        case (align)
          ALIGN_LEFT:  x = col + pos;
          ALIGN_RIGHT: x = PAGE_SIZE - 1 - (len - 1 - pos);
          default:     x = PAGE_SIZE / 2 - len / 2 + pos;
        endcase
        put(row, x, code);
        return;
      end
      if (code < CHAR_A || code > CHAR_Z)
        return;
      case (align)
        ALIGN_LEFT:  x = col + GLYPH_PITCH * pos;
        ALIGN_RIGHT: x = PAGE_SIZE - GLYPH_PITCH - GLYPH_PITCH * (len - 1 - pos);
        default:     x = PAGE_SIZE / 2 - (GLYPH_PITCH / 2) * len + GLYPH_PITCH * pos;
      endcase
      g = glyphs[code - CHAR_A];
      for (int i = 0; i < GLYPH_ROWS; i++)
        for (int j = 0; j < GLYPH_COLS; j++)
          if (g[GLYPH_COLS * (GLYPH_ROWS - 1 - i) + (GLYPH_COLS - 1 - j)])
            put(row + i, x + j, CELL_INK);
    endfunction

    function void note_request(bit [1:0] cmd, bit [1:0] align, bit big_font, bit [5:0] row,
                               bit [5:0] col, bit [7:0] tlen, bit [7:0] pos,
                               bit [7:0] code);
      case (cmd)
        CMD_DRAW:  plot(align, big_font, int'(row), int'(col), int'(tlen), int'(pos), code);
        CMD_READ:  pending_reads = {pending_reads, cells[int'(row) * PAGE_SIZE + int'(col)]};
        CMD_CLEAR: wipe();
        default:   ;
      endcase
    endfunction

    function void check_cell(logic [7:0] actual);
      bit [7:0] want;
      if (pending_reads.size() == 0) begin
        $error("out_cell_value: no read pending, actual %0d", actual);
        errors++;
        return;
      end
      want = pending_reads.pop_front();
      if (actual !== want) begin
        $error("out_cell_value: expected %0d, actual %0d", want, actual);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_command = '0;
  logic [1:0] in_align = '0;
  logic       in_large_font = 1'b0;
  logic [5:0] in_row = '0;
  logic [5:0] in_column = '0;
  logic [7:0] in_text_length = '0;
  logic [7:0] in_char_position = '0;
  logic [7:0] in_char_code = '0;
  logic       out_strobe;
  logic [7:0] out_cell_value;

  page_mirror  mirror;
  int          idle_pct = 0;
  int unsigned cycle_count = 0;

  // Current string that draws and nearby reads are aimed at
  logic [1:0] str_align;
  logic       str_large;
  logic [5:0] str_row;
  logic [5:0] str_col;
  logic [7:0] str_len;

  glyph_text_blitter u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_align         (in_align),
    .in_large_font    (in_large_font),
    .in_row           (in_row),
    .in_column        (in_column),
    .in_text_length   (in_text_length),
    .in_char_position (in_char_position),
    .in_char_code     (in_char_code),
    .out_strobe       (out_strobe),
    .out_cell_value   (out_cell_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      mirror.check_cell(out_cell_value);
  end

  task automatic request(input logic [1:0] cmd, input logic [1:0] align,
                         input logic big_font,
                         input logic [5:0] row, input logic [5:0] col,
                         input logic [7:0] tlen, input logic [7:0] pos,
                         input logic [7:0] code);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start            <= 1'b1;
    in_command       <= cmd;
    in_align         <= align;
    in_large_font    <= big_font;
    in_row           <= row;
    in_column        <= col;
    in_text_length   <= tlen;
    in_char_position <= pos;
    in_char_code     <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
    mirror.note_request(cmd, align, big_font, row, col, tlen, pos, code);
  endtask

  task automatic pick_string();
    int sel;
    sel = $urandom_range(0, 99);
    str_align = 2'($urandom_range(0, 2));
    str_large = 1'($urandom_range(0, 1));
    str_row   = 6'($urandom);
    str_col   = 6'($urandom);
    if (sel < 80)
      str_len = 8'($urandom_range(1, 10));
    else if (sel < 95)
      str_len = 8'($urandom_range(11, 255));
    else
      str_len = 8'd0;
  endtask

  task automatic random_request();
    int         pick;
    logic [1:0] cmd, al;
    logic       lg;
    logic [5:0] r, c;
    logic [7:0] tl, ps, cd;
    pick = $urandom_range(0, 99);
    cmd = 2'($urandom);
    al  = 2'($urandom);
    lg  = 1'($urandom);
    r   = 6'($urandom);
    c   = 6'($urandom);
    tl  = 8'($urandom);
    ps  = 8'($urandom);
    cd  = 8'($urandom);
    if (pick == 0) begin
      cmd = CMD_CLEAR;
    end else if (pick < 46) begin
      if ($urandom_range(0, 9) == 0)
        pick_string();
      cmd = CMD_DRAW;
      al  = str_align;
      lg  = str_large;
      r   = str_row;
      c   = str_col;
      tl  = str_len;
      if (str_len != 0 && $urandom_range(0, 99) < 85)
        ps = 8'($urandom_range(0, int'(str_len) - 1));
      if ($urandom_range(0, 9) == 0)
        cd = CELL_SPACE;
      else if (str_large && $urandom_range(0, 8) != 0)
        cd = CHAR_A + 8'($urandom_range(0, 25));
    end else if (pick < 90) begin
      cmd = CMD_READ;
      // aim most reads at the rows the current string covers
      if ($urandom_range(0, 9) < 7) begin
        r = str_row + 6'($urandom_range(0, 5));
        if (str_align == ALIGN_LEFT)
          c = str_col + 6'($urandom_range(0, 40));
      end
    end
    request(cmd, al, lg, r, c, tl, ps, cd);
  endtask

  initial begin
    mirror = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    request(CMD_READ,  ALIGN_LEFT,   1'b0, 6'd0,  6'd0,  8'd0,   8'd0,   8'd0);
    request(CMD_DRAW,  ALIGN_LEFT,   1'b0, 6'd0,  6'd0,  8'd3,   8'd0,   8'hFF);
    request(CMD_DRAW,  ALIGN_LEFT,   1'b0, 6'd63, 6'd63, 8'd2,   8'd1,   "q");
    request(CMD_DRAW,  ALIGN_LEFT,   1'b0, 6'd63, 6'd63, 8'd2,   8'd0,   8'h00);
    request(CMD_DRAW,  ALIGN_RIGHT,  1'b0, 6'd5,  6'd0,  8'd255, 8'd254, "r");
    request(CMD_DRAW,  ALIGN_RIGHT,  1'b0, 6'd5,  6'd0,  8'd255, 8'd0,   "k");
    request(CMD_DRAW,  ALIGN_CENTRE, 1'b0, 6'd10, 6'd0,  8'd4,   8'd0,   "m");
    request(CMD_DRAW,  ALIGN_LEFT,   1'b0, 6'd0,  6'd1,  8'd3,   8'd1,   CELL_SPACE);
    request(CMD_DRAW,  ALIGN_LEFT,   1'b1, 6'd20, 6'd0,  8'd1,   8'd0,   "A");
    request(CMD_DRAW,  ALIGN_RIGHT,  1'b1, 6'd62, 6'd0,  8'd2,   8'd1,   "Z");
    request(CMD_DRAW,  ALIGN_CENTRE, 1'b1, 6'd40, 6'd0,  8'd3,   8'd2,   "M");
    request(CMD_DRAW,  ALIGN_LEFT,   1'b1, 6'd30, 6'd10, 8'd1,   8'd0,   "a");
    request(CMD_DRAW,  ALIGN_LEFT,   1'b1, 6'd30, 6'd10, 8'd1,   8'd0,   "@");
    request(CMD_DRAW,  ALIGN_LEFT,   1'b1, 6'd30, 6'd20, 8'd1,   8'd0,   "[");
    request(CMD_DRAW,  ALIGN_LEFT,   1'b0, 6'd30, 6'd30, 8'd5,   8'd5,   "x");
    request(CMD_DRAW,  ALIGN_NONE,   1'b0, 6'd30, 6'd31, 8'd5,   8'd0,   "y");
    request(CMD_NONE,  ALIGN_LEFT,   1'b0, 6'd30, 6'd32, 8'd1,   8'd0,   "w");
    request(CMD_READ,  ALIGN_LEFT,   1'b0, 6'd0,  6'd0,  8'd0,   8'd0,   8'd0);
    request(CMD_READ,  ALIGN_LEFT,   1'b0, 6'd63, 6'd63, 8'd0,   8'd0,   8'd0);
    request(CMD_READ,  ALIGN_LEFT,   1'b0, 6'd5,  6'd63, 8'd0,   8'd0,   8'd0);
    request(CMD_READ,  ALIGN_LEFT,   1'b0, 6'd10, 6'd30, 8'd0,   8'd0,   8'd0);
    request(CMD_READ,  ALIGN_LEFT,   1'b0, 6'd20, 6'd1,  8'd0,   8'd0,   8'd0);
    request(CMD_READ,  ALIGN_LEFT,   1'b0, 6'd62, 6'd58, 8'd0,   8'd0,   8'd0);
    request(CMD_CLEAR, ALIGN_LEFT,   1'b0, 6'd0,  6'd0,  8'd0,   8'd0,   8'd0);
    request(CMD_READ,  ALIGN_LEFT,   1'b0, 6'd0,  6'd0,  8'd0,   8'd0,   8'd0);

    pick_string();
    idle_pct = 0;
    repeat (PHASE_REQUESTS) random_request();
    idle_pct = 54;
    repeat (PHASE_REQUESTS) random_request();
    idle_pct = 25;
    repeat (PHASE_REQUESTS) random_request();

    @(negedge clk);
    start <= 1'b0;
    while (mirror.pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/gtb_pkg.sv
rtl/gtb_front.sv
rtl/gtb_queue.sv
rtl/gtb_back.sv
rtl/glyph_text_blitter.sv
dv/glyph_text_blitter_test.sv
